// File: design/lcgrm_pkg.sv
`timescale 1ns / 1ps

package lcgrm_pkg;

   // Width of the data fields on the ports. Only the low WORD_BITS bits carry data.
   localparam int DATA_BITS = 32;

   localparam int CSR_IDX_BITS = 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MULTIPLIER = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INCREMENT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODULUS    = 2'd2;

   localparam logic MODE_SEED = 1'b0;
   localparam logic MODE_STEP = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } recip_stat_type;

endpackage

// File: design/lcg_with_reciprocal_modulus.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_mode, req_seed_value
// rsp_      out        rsp_valid/rsp_stall   rsp_random_value
// csr_      in         csr_valid/csr_ready   csr_index, csr_wdata
//
// A step item makes three passes through the one shared multiplier (S_MA, S_MB, S_MC), each
// followed by an add, shift or subtract stage (S_T, S_Q, S_X); rsp_valid is registered when
// S_X finds the output free. A seed item runs the bit-serial divider and then the
// one-bit-a-cycle normalization of the reciprocal; req_stall holds until the unit is done.
// Reset is synchronous; the generator state, reciprocal, shift and divisor clear to zero.
// A new item is taken while an earlier result waits under rsp_stall; the last step stage holds.
module lcg_with_reciprocal_modulus import lcgrm_pkg::*; #(
   parameter int WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_mode,
   input  logic [DATA_BITS-1:0]     req_seed_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [DATA_BITS-1:0]     rsp_random_value,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [DATA_BITS-1:0]     csr_wdata
);

   localparam int W  = WORD_BITS;
   localparam int DW = 2 * W;
   localparam int SW = $clog2(DW);

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_SEED = 8'b00000010,
      S_MA   = 8'b00000100,
      S_T    = 8'b00001000,
      S_MB   = 8'b00010000,
      S_Q    = 8'b00100000,
      S_MC   = 8'b01000000,
      S_X    = 8'b10000000
   } state_type;

   state_type       state_ff, state_in;
   logic [W-1:0]    mult_ff, mult_in;
   logic [W-1:0]    inc_ff, inc_in;
   logic [W-1:0]    mod_ff, mod_in;
   logic [W-1:0]    cur_ff, cur_in;
   logic [W-1:0]    t_ff, t_in;
   logic [W-1:0]    q_ff, q_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]    rsp_value_ff, rsp_value_in;

   logic            req_xfer;
   logic            rsp_free;
   logic            recip_start;
   logic [W:0]      recip;
   logic [SW-1:0]   shift;
   logic [W-1:0]    divisor;
   recip_stat_type  recip_stat;

   logic            mul_en;
   logic [W-1:0]    mul_a, mul_b;
   logic [DW-1:0]   prod;
   logic [W-1:0]    sum_hi;
   logic [W-1:0]    x_val;

   assign req_stall   = state_ff != S_IDLE;
   assign req_xfer    = req_valid && !req_stall;
   assign recip_start = req_xfer && (req_mode == MODE_SEED);
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;
   assign csr_ready   = 1'b1;

   lcgrm_recip #(.W(W)) u_recip (
      .clock   (clock),
      .reset   (reset),
      .start   (recip_start),
      .modulus (mod_ff),
      .recip   (recip),
      .shift   (shift),
      .divisor (divisor),
      .stat    (recip_stat)
   );

   always_comb begin
      mul_en = 1'b0;
      mul_a  = mult_ff;
      mul_b  = cur_ff;
      unique case (state_ff)
         S_MA: begin
            mul_en = 1'b1;
         end
         S_MB: begin
            mul_en = 1'b1;
            mul_a  = recip[W-1:0];
            mul_b  = t_ff;
         end
         S_MC: begin
            mul_en = 1'b1;
            mul_a  = q_ff;
            mul_b  = divisor;
         end
         default: begin
         end
      endcase
   end

   lcgrm_mul #(.W(W)) u_mul (
      .clock (clock),
      .en    (mul_en),
      .a     (mul_a),
      .b     (mul_b),
      .prod  (prod)
   );

   // The reciprocal carries one bit above the multiplier width; its weight is added here.
   assign sum_hi = prod[DW-1:W] + (recip[W] ? t_ff : '0);
   assign x_val  = t_ff - prod[W-1:0];

   always_comb begin
      mult_in = mult_ff;
      inc_in  = inc_ff;
      mod_in  = mod_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MULTIPLIER: mult_in = csr_wdata[W-1:0];
            CSR_INCREMENT:  inc_in  = csr_wdata[W-1:0];
            CSR_MODULUS:    mod_in  = csr_wdata[W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      t_in         = t_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_mode == MODE_SEED) begin
                  cur_in   = req_seed_value[W-1:0];
                  state_in = S_SEED;
               end else begin
                  state_in = S_MA;
               end
            end
         end
         S_SEED: begin
            if (recip_stat.done) begin
               state_in = S_IDLE;
            end
         end
         S_MA: state_in = S_T;
         S_T: begin
            t_in     = prod[W-1:0] + inc_ff;
            state_in = S_MB;
         end
         S_MB: state_in = S_Q;
         S_Q: begin
            q_in     = W'({sum_hi, prod[W-1:0]} >> shift);
            state_in = S_MC;
         end
         S_MC: state_in = S_X;
         S_X: begin
            if (rsp_free) begin
               cur_in       = x_val;
               rsp_value_in = x_val;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cur_ff       <= '0;
         mult_ff      <= W'(1);
         inc_ff       <= '0;
         mod_ff       <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cur_ff       <= cur_in;
         mult_ff      <= mult_in;
         inc_ff       <= inc_in;
         mod_ff       <= mod_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff         <= t_in;
      q_ff         <= q_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = DATA_BITS'(rsp_value_ff);

`ifndef SYNTHESIS
   a_rsp_from_last_stage: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_X))
      else $error("result appeared without a finished step");

   a_seed_runs_divider: assert property (@(posedge clock) disable iff (reset)
      recip_start |=> (state_ff == S_SEED) && recip_stat.busy)
      else $error("seed transfer did not start the reciprocal unit");

   a_divider_only_in_seed: assert property (@(posedge clock) disable iff (reset)
      recip_stat.busy |-> (state_ff == S_SEED))
      else $error("reciprocal unit busy outside a seed item");

   a_seed_no_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEED) |=> !$rose(rsp_valid_ff))
      else $error("seed item produced a result");
`endif

endmodule

// File: design/lcgrm_mul.sv
`timescale 1ns / 1ps

module lcgrm_mul import lcgrm_pkg::*; #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           en,
   input  logic [W-1:0]   a,
   input  logic [W-1:0]   b,
   output logic [2*W-1:0] prod
);

   logic [2*W-1:0] prod_ff;
   logic [2*W-1:0] prod_in;

   assign prod_in = (2*W)'(a) * (2*W)'(b);

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// File: design/lcgrm_recip.sv
`timescale 1ns / 1ps

module lcgrm_recip import lcgrm_pkg::*; #(
   parameter int W = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [W-1:0]                modulus,
   output logic [W:0]                  recip,
   output logic [$clog2(2*W)-1:0]      shift,
   output logic [W-1:0]                divisor,
   output recip_stat_type              stat
);

   localparam int DW = 2 * W;
   localparam int RW = W + 1;
   localparam int CW = $clog2(DW);

   typedef enum logic [4:0] {
      R_IDLE = 5'b00001,
      R_DIV  = 5'b00010,
      R_NORM = 5'b00100,
      R_INC  = 5'b01000,
      R_ODD  = 5'b10000
   } rstate_type;

   rstate_type     state_ff, state_in;
   logic [W:0]     rem_ff, rem_in;
   logic [DW-1:0]  quo_ff, quo_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [CW-1:0]  sh_ff, sh_in;
   logic [W-1:0]   m_ff, m_in;

   logic [W:0]     rem_sh;
   logic           rem_ge;

   // The dividend is a single one in its top bit, so only the first step shifts in a one.
   // A zero divisor makes every compare succeed and the quotient comes out all ones.
   assign rem_sh = {rem_ff[W-1:0], (cnt_ff == CW'(DW-1))};
   assign rem_ge = rem_sh >= {1'b0, m_ff};

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      sh_in    = sh_ff;
      m_in     = m_ff;
      unique case (state_ff)
         R_IDLE: begin
            if (start) begin
               rem_in   = '0;
               quo_in   = '0;
               cnt_in   = CW'(DW-1);
               sh_in    = CW'(DW-1);
               m_in     = modulus;
               state_in = R_DIV;
            end
         end
         R_DIV: begin
            rem_in = rem_ge ? (rem_sh - {1'b0, m_ff}) : rem_sh;
            quo_in = {quo_ff[DW-2:0], rem_ge};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = R_NORM;
            end
         end
         R_NORM: begin
            if (quo_ff[DW-1:W] != '0) begin
               quo_in = quo_ff >> 1;
               sh_in  = sh_ff - CW'(1);
            end else begin
               state_in = R_INC;
            end
         end
         R_INC: begin
            quo_in   = {{(DW-RW){1'b0}}, quo_ff[W:0] + RW'(1)};
            state_in = R_ODD;
         end
         R_ODD: begin
            if (!quo_ff[0]) begin
               quo_in = quo_ff >> 1;
               sh_in  = sh_ff - CW'(1);
            end
            state_in = R_IDLE;
         end
         default: begin
            state_in = R_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= R_IDLE;
         quo_ff   <= '0;
         sh_ff    <= '0;
         m_ff     <= '0;
      end else begin
         state_ff <= state_in;
         quo_ff   <= quo_in;
         sh_ff    <= sh_in;
         m_ff     <= m_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign recip     = quo_ff[W:0];
   assign shift     = sh_ff;
   assign divisor   = m_ff;
   assign stat.busy = state_ff != R_IDLE;
   assign stat.done = state_ff == R_ODD;

endmodule
